@@ src/tbw_pkg.sv @@
package tbw_pkg;

  localparam int COORD_W          = 16;
  localparam int WEIGHT_W         = 16;
  localparam int WEIGHT_FRAC_BITS = 14;

  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int NORM_W  = SQ_W + 2;

  // The remainder holds the sub-area norm shifted by twice the weight fraction bits,
  // and the saturation test shifts the full norm by twice the weight width.
  localparam int SCALE_SH = 2 * WEIGHT_FRAC_BITS;
  localparam int SAT_SH   = 2 * WEIGHT_W;
  localparam int CALC_W   = NORM_W + ((SCALE_SH > SAT_SH) ? SCALE_SH : SAT_SH) + 2;

  localparam int CROSS_STAGES = 5;
  localparam int ROOT_STAGES  = WEIGHT_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic [NORM_W-1:0]         norm_t;
  typedef logic [WEIGHT_W-1:0]       weight_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
    diff_t z;
  } dvec_t;

  typedef struct packed {
    logic    sat;
    weight_t q;
  } root_res_t;

endpackage

@@ src/tbw_req_if.sv @@
interface tbw_req_if;
  import tbw_pkg::*;

  logic   valid;
  logic   ready;
  coord_t px;
  coord_t py;
  coord_t pz;
  coord_t ax;
  coord_t ay;
  coord_t az;
  coord_t bx;
  coord_t by;
  coord_t bz;
  coord_t cx;
  coord_t cy;
  coord_t cz;

  modport source (
    output valid, px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz,
    input  ready
  );

  modport sink (
    input  valid, px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz,
    output ready
  );

endinterface

@@ src/tbw_rsp_if.sv @@
interface tbw_rsp_if;
  import tbw_pkg::*;

  logic    valid;
  logic    ready;
  weight_t weight_a;
  weight_t weight_b;
  weight_t weight_c;
  logic    degenerate;
  logic    saturated;

  modport source (
    output valid, weight_a, weight_b, weight_c, degenerate, saturated,
    input  ready
  );

  modport sink (
    input  valid, weight_a, weight_b, weight_c, degenerate, saturated,
    output ready
  );

endinterface

@@ src/triangle_barycentric_weights_core.sv @@
// Barycentric weights of a query point against a 3D triangle, from the ratio
// of sub-triangle to full-triangle cross-product lengths, as unsigned Q2.14.
// One request is accepted every cycle unless the output stalls. Five stages
// form the differences, cross products, squares and squared norms, one
// stage sets up the square roots, sixteen stages each resolve one weight
// bit, and a last stage holds the result. A stalled output
// freezes the whole pipeline, so the request side is ready whenever the
// output register is empty or being taken.
module triangle_barycentric_weights_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  tbw_req_if.sink          req_i,
  tbw_rsp_if.source        rsp_o
);
  import tbw_pkg::*;

  logic      en;
  logic      cross_valid;
  norm_t     full, sub_a, sub_b, sub_c;
  root_res_t res_a, res_b, res_c;

  logic [ROOT_STAGES:0] valid_q;
  logic [ROOT_STAGES:0] degen_q;

  logic    out_valid_q;
  weight_t wa_q, wb_q, wc_q;
  logic    degen_out_q, sat_out_q;

  assign en          = !out_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  tbw_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (req_i.valid),
    .p_i     ({req_i.px, req_i.py, req_i.pz}),
    .a_i     ({req_i.ax, req_i.ay, req_i.az}),
    .b_i     ({req_i.bx, req_i.by, req_i.bz}),
    .c_i     ({req_i.cx, req_i.cy, req_i.cz}),
    .valid_o (cross_valid),
    .full_o  (full),
    .sub_a_o (sub_a),
    .sub_b_o (sub_b),
    .sub_c_o (sub_c)
  );

  tbw_root u_root_a (.clk_i(clk_i), .en_i(en), .sub_i(sub_a), .full_i(full), .res_o(res_a));
  tbw_root u_root_b (.clk_i(clk_i), .en_i(en), .sub_i(sub_b), .full_i(full), .res_o(res_b));
  tbw_root u_root_c (.clk_i(clk_i), .en_i(en), .sub_i(sub_c), .full_i(full), .res_o(res_c));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      valid_q     <= {valid_q[ROOT_STAGES-1:0], cross_valid};
      out_valid_q <= valid_q[ROOT_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      degen_q     <= {degen_q[ROOT_STAGES-1:0], full == '0};
      degen_out_q <= degen_q[ROOT_STAGES];
      sat_out_q   <= !degen_q[ROOT_STAGES] && (res_a.sat || res_b.sat || res_c.sat);
      wa_q <= degen_q[ROOT_STAGES] ? '0 : (res_a.sat ? WEIGHT_MAX : res_a.q);
      wb_q <= degen_q[ROOT_STAGES] ? '0 : (res_b.sat ? WEIGHT_MAX : res_b.q);
      wc_q <= degen_q[ROOT_STAGES] ? '0 : (res_c.sat ? WEIGHT_MAX : res_c.q);
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.weight_a   = wa_q;
  assign rsp_o.weight_b   = wb_q;
  assign rsp_o.weight_c   = wc_q;
  assign rsp_o.degenerate = degen_out_q;
  assign rsp_o.saturated  = sat_out_q;

endmodule

@@ src/tbw_cross.sv @@
module tbw_cross (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  tbw_pkg::vec_t  p_i,
  input  tbw_pkg::vec_t  a_i,
  input  tbw_pkg::vec_t  b_i,
  input  tbw_pkg::vec_t  c_i,
  output logic           valid_o,
  output tbw_pkg::norm_t full_o,
  output tbw_pkg::norm_t sub_a_o,
  output tbw_pkg::norm_t sub_b_o,
  output tbw_pkg::norm_t sub_c_o
);
  import tbw_pkg::*;

  // Slot 0 is the full triangle, slots 1 to 3 the sub-triangles of A, B and C.
  localparam int NCROSS = 4;

  logic [CROSS_STAGES-1:0] valid_q;

  dvec_t e0_d, e1_d, fa_d, fb_d, fc_d;
  dvec_t u_q [NCROSS];
  dvec_t v_q [NCROSS];

  logic signed [PROD_W-1:0]  prod_q [NCROSS][6];
  logic signed [CROSS_W-1:0] cr_d   [NCROSS][3];
  logic [MAG_W-1:0]          mag_q  [NCROSS][3];
  logic [SQ_W-1:0]           sq_q   [NCROSS][3];
  norm_t                     norm_q [NCROSS];

  always_comb begin
    e0_d = '{DIFF_W'(a_i.x) - DIFF_W'(b_i.x), DIFF_W'(a_i.y) - DIFF_W'(b_i.y),
             DIFF_W'(a_i.z) - DIFF_W'(b_i.z)};
    e1_d = '{DIFF_W'(a_i.x) - DIFF_W'(c_i.x), DIFF_W'(a_i.y) - DIFF_W'(c_i.y),
             DIFF_W'(a_i.z) - DIFF_W'(c_i.z)};
    fa_d = '{DIFF_W'(a_i.x) - DIFF_W'(p_i.x), DIFF_W'(a_i.y) - DIFF_W'(p_i.y),
             DIFF_W'(a_i.z) - DIFF_W'(p_i.z)};
    fb_d = '{DIFF_W'(b_i.x) - DIFF_W'(p_i.x), DIFF_W'(b_i.y) - DIFF_W'(p_i.y),
             DIFF_W'(b_i.z) - DIFF_W'(p_i.z)};
    fc_d = '{DIFF_W'(c_i.x) - DIFF_W'(p_i.x), DIFF_W'(c_i.y) - DIFF_W'(p_i.y),
             DIFF_W'(c_i.z) - DIFF_W'(p_i.z)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[CROSS_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q[0] <= e0_d;
      v_q[0] <= e1_d;
      u_q[1] <= fb_d;
      v_q[1] <= fc_d;
      u_q[2] <= fc_d;
      v_q[2] <= fa_d;
      u_q[3] <= fa_d;
      v_q[3] <= fb_d;
    end
  end

  always_comb begin
    for (int k = 0; k < NCROSS; k++) begin
      for (int j = 0; j < 3; j++) begin
        cr_d[k][j] = CROSS_W'(prod_q[k][2*j]) - CROSS_W'(prod_q[k][2*j+1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NCROSS; k++) begin
        prod_q[k][0] <= PROD_W'(u_q[k].y) * PROD_W'(v_q[k].z);
        prod_q[k][1] <= PROD_W'(u_q[k].z) * PROD_W'(v_q[k].y);
        prod_q[k][2] <= PROD_W'(u_q[k].z) * PROD_W'(v_q[k].x);
        prod_q[k][3] <= PROD_W'(u_q[k].x) * PROD_W'(v_q[k].z);
        prod_q[k][4] <= PROD_W'(u_q[k].x) * PROD_W'(v_q[k].y);
        prod_q[k][5] <= PROD_W'(u_q[k].y) * PROD_W'(v_q[k].x);
        for (int j = 0; j < 3; j++) begin
          mag_q[k][j] <= cr_d[k][j][CROSS_W-1] ? MAG_W'(-cr_d[k][j]) : MAG_W'(cr_d[k][j]);
          sq_q[k][j]  <= SQ_W'(mag_q[k][j]) * SQ_W'(mag_q[k][j]);
        end
        norm_q[k] <= NORM_W'(sq_q[k][0]) + NORM_W'(sq_q[k][1]) + NORM_W'(sq_q[k][2]);
      end
    end
  end

  assign valid_o = valid_q[CROSS_STAGES-1];
  assign full_o  = norm_q[0];
  assign sub_a_o = norm_q[1];
  assign sub_b_o = norm_q[2];
  assign sub_c_o = norm_q[3];

endmodule

@@ src/tbw_root.sv @@
module tbw_root (
  input  logic               clk_i,
  input  logic               en_i,
  input  tbw_pkg::norm_t     sub_i,
  input  tbw_pkg::norm_t     full_i,
  output tbw_pkg::root_res_t res_o
);
  import tbw_pkg::*;

  typedef logic [CALC_W-1:0] calc_t;

  calc_t   rem_q  [ROOT_STAGES+1];
  calc_t   acc_q  [ROOT_STAGES+1];
  norm_t   full_q [ROOT_STAGES+1];
  weight_t q_q    [ROOT_STAGES+1];
  logic    sat_q  [ROOT_STAGES+1];

  calc_t delta_d [ROOT_STAGES];
  logic  take_d  [ROOT_STAGES];

  calc_t rem0_d;

  assign rem0_d = CALC_W'(sub_i) << SCALE_SH;

  // Each step decides one weight bit, most significant first. The accumulator
  // holds q times the full norm, so the trial cost is a shifted add.
  always_comb begin
    for (int s = 0; s < ROOT_STAGES; s++) begin
      delta_d[s] = (acc_q[s] << (ROOT_STAGES - s))
                 + (CALC_W'(full_q[s]) << (2 * (ROOT_STAGES - 1 - s)));
      take_d[s]  = delta_d[s] <= rem_q[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem0_d;
      acc_q[0]  <= '0;
      full_q[0] <= full_i;
      q_q[0]    <= '0;
      sat_q[0]  <= (CALC_W'(full_i) << SAT_SH) <= rem0_d;
      for (int s = 0; s < ROOT_STAGES; s++) begin
        rem_q[s+1]  <= take_d[s] ? rem_q[s] - delta_d[s] : rem_q[s];
        acc_q[s+1]  <= take_d[s] ? acc_q[s] + (CALC_W'(full_q[s]) << (ROOT_STAGES - 1 - s))
                                 : acc_q[s];
        q_q[s+1]    <= take_d[s] ? q_q[s] | (weight_t'(1) << (ROOT_STAGES - 1 - s)) : q_q[s];
        full_q[s+1] <= full_q[s];
        sat_q[s+1]  <= sat_q[s];
      end
    end
  end

  assign res_o.q   = q_q[ROOT_STAGES];
  assign res_o.sat = sat_q[ROOT_STAGES];

endmodule
